>>> rtl/scsp_pkg.sv
// shared types, constants and helpers of the s-curve segment planner
`timescale 1ns / 1ps

package scsp_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegJerkLimit  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegAccelLimit = 2'd1;

  localparam logic [30:0] LimitReset = 31'd65536;
  localparam logic [30:0] TimeMax    = 31'h7fff_ffff;
  localparam logic signed [31:0] S32Max = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32Min = 32'sh8000_0000;
  localparam logic signed [34:0] SatHi  = 35'sh0_7fff_ffff;
  localparam logic signed [34:0] SatLo  = 35'sh7_8000_0000;

  // floor(m / 6) == (m * Div6Recip) >> Div6Shift for any 32-bit m
  localparam logic [31:0] Div6Recip = 32'haaaa_aaab;
  localparam int unsigned Div6Shift = 34;

  typedef struct packed {
    logic signed [31:0] v0;
    logic signed [31:0] avg;
    logic signed [31:0] am;
    logic signed [31:0] jm;
    logic [30:0]        tc;
    logic [30:0]        qa;
    logic [30:0]        tp;
    logic [30:0]        t3c;
    logic signed [31:0] tm;
    logic               cphase;
    logic signed [31:0] p_c;
    logic signed [31:0] m_b;
    logic signed [31:0] m_c;
    logic signed [31:0] m_d;
    logic signed [31:0] m_f;
    logic signed [31:0] q1;
    logic signed [31:0] v1c;
    logic signed [31:0] pp;
    logic signed [31:0] m_h;
    logic signed [31:0] q2;
    logic signed [31:0] v2c;
    logic signed [31:0] q3;
    logic signed [31:0] x1;
  } side_t;

  typedef struct packed {
    logic               cphase;
    logic signed [31:0] am;
    logic signed [31:0] jm;
    logic [30:0]        t1;
    logic [30:0]        t2;
    logic [30:0]        t3;
    logic signed [31:0] v1;
    logic signed [31:0] v2;
    logic signed [31:0] x1;
    logic signed [31:0] x2;
    logic signed [31:0] x3;
  } res_t;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] x);
    logic signed [31:0] r;
    if (x > SatHi) begin
      r = S32Max;
    end else if (x < SatLo) begin
      r = S32Min;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // halve, truncating toward zero
  function automatic logic signed [32:0] half33(input logic signed [32:0] x);
    logic signed [33:0] t;
    t = {x[32], x} + {33'd0, x[32]};
    return t[33:1];
  endfunction

endpackage

>>> rtl/scsp_div.sv
// pipelined restoring divider lanes, one quotient bit per stage, saturating
`timescale 1ns / 1ps

module scsp_div #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned LANES     = 3
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  scsp_pkg::side_t side_i,
  input  logic [31:0]     num_i [LANES],
  input  logic [30:0]     den_i [LANES],
  output logic            valid_o,
  output scsp_pkg::side_t side_o,
  output logic [30:0]     quo_o [LANES]
);
  import scsp_pkg::*;

  localparam int unsigned NumW  = 32 + FRAC_BITS;
  localparam int unsigned QBits = 31;
  localparam int unsigned Depth = QBits + 1;

  logic [NumW-1:0] rem_q [Depth-1][LANES];
  logic [30:0]     den_q [Depth-1][LANES];
  logic [30:0]     quo_q [Depth][LANES];
  logic            sat_q [Depth][LANES];
  logic            valid_q [Depth];
  side_t           side_q [Depth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane0
    logic [NumW-1:0] num_ext;
    assign num_ext = {num_i[l], {FRAC_BITS{1'b0}}};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[0][l] <= num_ext;
        den_q[0][l] <= den_i[l];
        quo_q[0][l] <= '0;
        // quotient would reach 2^31, or the divisor is zero
        sat_q[0][l] <= (num_ext >> QBits) >= NumW'(den_i[l]);
      end
    end
  end

  for (genvar s = 1; s < Depth; s++) begin : g_stage
    localparam int unsigned Bit = QBits - s;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= valid_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s] <= side_q[s-1];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic hit;
      assign hit = (rem_q[s-1][l] >> Bit) >= NumW'(den_q[s-1][l]);

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          quo_q[s][l] <= quo_q[s-1][l] | (hit ? (31'd1 << Bit) : 31'd0);
          sat_q[s][l] <= sat_q[s-1][l];
        end
      end

      if (s < Depth - 1) begin : g_rem
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            rem_q[s][l] <= hit ? rem_q[s-1][l] - (NumW'(den_q[s-1][l]) << Bit)
                               : rem_q[s-1][l];
            den_q[s][l] <= den_q[s-1][l];
          end
        end
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign quo_o[l] = sat_q[Depth-1][l] ? TimeMax : quo_q[Depth-1][l];
  end

  assign valid_o = valid_q[Depth-1];
  assign side_o  = side_q[Depth-1];

endmodule

>>> rtl/scsp_sqrt.sv
// pipelined digit-by-digit integer square root, one root bit per stage
`timescale 1ns / 1ps

module scsp_sqrt #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  scsp_pkg::side_t side_i,
  input  logic [30:0]     rad_i,
  output logic            valid_o,
  output scsp_pkg::side_t side_o,
  output logic [30:0]     root_o
);
  import scsp_pkg::*;

  localparam int unsigned RadW  = 31 + FRAC_BITS;
  localparam int unsigned RootW = (RadW + 1) / 2;
  localparam int unsigned RemW  = 2 * RootW + 1;
  localparam int unsigned Depth = RootW + 1;

  logic [RemW-1:0]  rem_q [Depth-1];
  logic [RootW-1:0] root_q [Depth];
  logic             valid_q [Depth];
  side_t            side_q [Depth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      rem_q[0]  <= RemW'({rad_i, {FRAC_BITS{1'b0}}});
      root_q[0] <= '0;
    end
  end

  for (genvar s = 1; s < Depth; s++) begin : g_stage
    localparam int unsigned Bit = RootW - s;
    logic [RemW-1:0] trial;
    logic            hit;

    // (2y + 2^bit) * 2^bit, the growth of the square when this bit is set
    assign trial = (RemW'(root_q[s-1]) << (Bit + 1)) | (RemW'(1) << (2 * Bit));
    assign hit   = rem_q[s-1] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= valid_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s] <= side_q[s-1];
        root_q[s] <= root_q[s-1] | (hit ? (RootW'(1) << Bit) : RootW'(0));
      end
    end

    if (s < Depth - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= hit ? rem_q[s-1] - trial : rem_q[s-1];
        end
      end
    end
  end

  assign valid_o = valid_q[Depth-1];
  assign side_o  = side_q[Depth-1];
  assign root_o  = 31'(root_q[Depth-1]);

endmodule

>>> rtl/scsp_qmul.sv
// parallel fixed-point multiplier lanes: product stage, then shift and saturate
`timescale 1ns / 1ps

module scsp_qmul #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned LANES     = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  scsp_pkg::side_t    side_i,
  input  logic signed [31:0] a_i [LANES],
  input  logic signed [31:0] b_i [LANES],
  output logic               valid_o,
  output scsp_pkg::side_t    side_o,
  output logic signed [31:0] r_o [LANES]
);
  import scsp_pkg::*;

  logic               valid_q [2];
  side_t              side_q [2];
  logic [63:0]        prod_q [LANES];
  logic               neg_q [LANES];
  logic signed [31:0] r_q [LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
      valid_q[1] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
      valid_q[1] <= valid_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      side_q[1] <= side_q[0];
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [31:0] mag_a, mag_b;
    logic [63:0] shifted;
    logic signed [31:0] res;

    assign mag_a   = a_i[l][31] ? 32'(-a_i[l]) : a_i[l];
    assign mag_b   = b_i[l][31] ? 32'(-b_i[l]) : b_i[l];
    assign shifted = prod_q[l] >> FRAC_BITS;

    always_comb begin
      if (!neg_q[l]) begin
        res = (shifted > 64'h7fff_ffff) ? S32Max : shifted[31:0];
      end else begin
        res = (shifted > 64'h8000_0000) ? S32Min : 32'(-shifted[31:0]);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        prod_q[l] <= 64'(mag_a) * 64'(mag_b);
        neg_q[l]  <= a_i[l][31] ^ b_i[l][31];
        r_q[l]    <= res;
      end
    end

    assign r_o[l] = r_q[l];
  end

  assign valid_o = valid_q[1];
  assign side_o  = side_q[1];

endmodule

>>> rtl/scsp_skid.sv
// two-entry output buffer that decouples the pipeline from the result stall
`timescale 1ns / 1ps

module scsp_skid (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  scsp_pkg::res_t data_i,
  input  logic           stall_i,
  output logic           valid_o,
  output scsp_pkg::res_t data_o,
  output logic           full_o,
  output logic [1:0]     count_o
);
  import scsp_pkg::*;

  res_t       buf_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign valid_o = cnt_q != 2'd0;
  assign full_o  = cnt_q == 2'd2;
  assign count_o = cnt_q;
  assign data_o  = buf_q[rd_q];
  assign pop     = valid_o && !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= data_i;
    end
  end

endmodule

>>> rtl/s_curve_segment_planner_core.sv
// s-curve segment planner top level: config, stage glue and output buffer
//
// Plans a jerk-limited velocity change from start_velocity_i to
// end_velocity_i using the jerk and acceleration limits in the config
// registers (index 0 jerk, 1 accel, written through cfg_we_i); the user
// must write them only while idle, as the block does not enforce it.
// Input beats are taken when in_valid_i is high and in_stall_o is low;
// result beats leave when out_valid_o is high and out_stall_i is low.
// One beat in gives one beat out, in order. Throughput is one beat per
// cycle while the output buffer is not full. The pipeline depth is set
// by the 32-stage bit-per-stage divider, the bit-per-stage square root
// and the three dependent multiplier stages behind it. A two-entry
// output buffer sits at the end; while it is full the whole pipeline
// freezes and in_stall_o goes high, so nothing is lost or repeated.
// Reset empties the pipeline and the buffer and loads both limits with
// 65536, which is 1.0 at the default FRACTION_BITS.
`timescale 1ns / 1ps

module s_curve_segment_planner_core #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [scsp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [30:0]                   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [31:0]            start_velocity_i,
  input  logic signed [31:0]            end_velocity_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          has_constant_phase_o,
  output logic signed [31:0]            signed_accel_o,
  output logic signed [31:0]            signed_jerk_o,
  output logic [30:0]                   time_end_ramp_up_o,
  output logic [30:0]                   time_end_constant_o,
  output logic [30:0]                   time_total_o,
  output logic signed [31:0]            velocity_after_ramp_up_o,
  output logic signed [31:0]            velocity_after_constant_o,
  output logic signed [31:0]            position_after_ramp_up_o,
  output logic signed [31:0]            position_after_constant_o,
  output logic signed [31:0]            position_total_o
);
  import scsp_pkg::*;

  localparam int unsigned DivLanes = 3;
  localparam int unsigned M1Lanes  = 6;
  localparam int unsigned M2Lanes  = 3;
  localparam int unsigned M3Lanes  = 1;

  // config registers
  logic [30:0] jerk_q, accel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jerk_q  <= LimitReset;
      accel_q <= LimitReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegJerkLimit:  jerk_q  <= cfg_wdata_i;
        RegAccelLimit: accel_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic       en;
  logic       skid_full;
  logic [1:0] skid_count;

  assign en         = !skid_full;
  assign in_stall_o = !en;

  // input stage
  logic              in_vld_q;
  side_t             in_side_d, in_side_q;
  logic [31:0]       dvm_d, dvm_q;
  logic [30:0]       a_q, j_q;
  logic signed [32:0] diff, vsum, avg33;
  logic              up;

  always_comb begin
    diff  = {end_velocity_i[31], end_velocity_i} - {start_velocity_i[31], start_velocity_i};
    vsum  = {end_velocity_i[31], end_velocity_i} + {start_velocity_i[31], start_velocity_i};
    avg33 = half33(vsum);
    up    = !diff[32] && (diff != 33'sd0);
    dvm_d = diff[32] ? 32'(-diff) : diff[31:0];
    in_side_d     = '0;
    in_side_d.v0  = start_velocity_i;
    in_side_d.avg = avg33[31:0];
    in_side_d.am  = up ? $signed({1'b0, accel_q}) : -$signed({1'b0, accel_q});
    in_side_d.jm  = up ? $signed({1'b0, jerk_q}) : -$signed({1'b0, jerk_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_side_q <= in_side_d;
      dvm_q     <= dvm_d;
      a_q       <= accel_q;
      j_q       <= jerk_q;
    end
  end

  // dividers: a/j, |dv|/a, |dv|/j
  logic [31:0] div_num [DivLanes];
  logic [30:0] div_den [DivLanes];
  logic [30:0] div_quo [DivLanes];
  logic        div_vld;
  side_t       div_side;

  assign div_num[0] = {1'b0, a_q};
  assign div_den[0] = j_q;
  assign div_num[1] = dvm_q;
  assign div_den[1] = a_q;
  assign div_num[2] = dvm_q;
  assign div_den[2] = j_q;

  scsp_div #(
    .FRAC_BITS (FRACTION_BITS),
    .LANES     (DivLanes)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_vld_q),
    .side_i  (in_side_q),
    .num_i   (div_num),
    .den_i   (div_den),
    .valid_o (div_vld),
    .side_o  (div_side),
    .quo_o   (div_quo)
  );

  side_t              sq_side_in;
  logic signed [32:0] tm;
  logic [31:0]        t3_sum;

  always_comb begin
    sq_side_in    = div_side;
    sq_side_in.tc = div_quo[0];
    sq_side_in.qa = div_quo[1];
    tm     = $signed({2'b00, div_quo[1]}) - $signed({2'b00, div_quo[0]});
    t3_sum = {1'b0, div_quo[1]} + {1'b0, div_quo[0]};
    sq_side_in.cphase = !tm[32] && (tm != 33'sd0);
    // only used with a constant phase, where it is positive and fits
    sq_side_in.tm  = sq_side_in.cphase ? tm[31:0] : 32'sd0;
    sq_side_in.t3c = t3_sum[31] ? TimeMax : t3_sum[30:0];
  end

  logic        sq_vld;
  side_t       sq_side;
  logic [30:0] sq_root;

  scsp_sqrt #(
    .FRAC_BITS (FRACTION_BITS)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_vld),
    .side_i  (sq_side_in),
    .rad_i   (div_quo[2]),
    .valid_o (sq_vld),
    .side_o  (sq_side),
    .root_o  (sq_root)
  );

  // first multiplier group
  side_t              m1_side_in, m1_side;
  logic signed [31:0] m1_a [M1Lanes];
  logic signed [31:0] m1_b [M1Lanes];
  logic signed [31:0] m1_r [M1Lanes];
  logic               m1_vld;

  always_comb begin
    m1_side_in    = sq_side;
    m1_side_in.tp = sq_root;
    m1_a[0] = sq_side.am;  m1_b[0] = $signed({1'b0, sq_side.tc});
    m1_a[1] = sq_side.am;  m1_b[1] = sq_side.tm;
    m1_a[2] = sq_side.v0;  m1_b[2] = $signed({1'b0, sq_side.tc});
    m1_a[3] = sq_side.avg; m1_b[3] = $signed({1'b0, sq_side.t3c});
    m1_a[4] = sq_side.jm;  m1_b[4] = $signed({1'b0, sq_root});
    m1_a[5] = sq_side.avg; m1_b[5] = $signed({1'b0, sq_root});
  end

  scsp_qmul #(
    .FRAC_BITS (FRACTION_BITS),
    .LANES     (M1Lanes)
  ) u_mul1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_vld),
    .side_i  (m1_side_in),
    .a_i     (m1_a),
    .b_i     (m1_b),
    .valid_o (m1_vld),
    .side_o  (m1_side),
    .r_o     (m1_r)
  );

  // stage a: v1 of the constant-phase plan
  side_t              sa_side_d, sa_side_q;
  logic               sa_vld_q;
  logic signed [32:0] p_half;

  always_comb begin
    sa_side_d     = m1_side;
    sa_side_d.p_c = m1_r[0];
    sa_side_d.m_b = m1_r[1];
    sa_side_d.m_c = m1_r[2];
    sa_side_d.m_d = m1_r[3];
    sa_side_d.q1  = m1_r[4];
    sa_side_d.m_f = m1_r[5];
    p_half        = half33({m1_r[0][31], m1_r[0]});
    sa_side_d.v1c = sat32({{3{m1_side.v0[31]}}, m1_side.v0} + {{2{p_half[32]}}, p_half});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_vld_q <= 1'b0;
    end else if (en) begin
      sa_vld_q <= m1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_side_q <= sa_side_d;
    end
  end

  // second multiplier group
  side_t              m2_side;
  logic signed [31:0] m2_a [M2Lanes];
  logic signed [31:0] m2_b [M2Lanes];
  logic signed [31:0] m2_r [M2Lanes];
  logic               m2_vld;

  always_comb begin
    m2_a[0] = sa_side_q.p_c; m2_b[0] = $signed({1'b0, sa_side_q.tc});
    m2_a[1] = sa_side_q.v1c; m2_b[1] = sa_side_q.tm;
    m2_a[2] = sa_side_q.q1;  m2_b[2] = $signed({1'b0, sa_side_q.tp});
  end

  scsp_qmul #(
    .FRAC_BITS (FRACTION_BITS),
    .LANES     (M2Lanes)
  ) u_mul2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sa_vld_q),
    .side_i  (sa_side_q),
    .a_i     (m2_a),
    .b_i     (m2_b),
    .valid_o (m2_vld),
    .side_o  (m2_side),
    .r_o     (m2_r)
  );

  // stage b: v2 of the constant-phase plan
  side_t sb_side_d, sb_side_q;
  logic  sb_vld_q;

  always_comb begin
    sb_side_d     = m2_side;
    sb_side_d.pp  = m2_r[0];
    sb_side_d.m_h = m2_r[1];
    sb_side_d.q2  = m2_r[2];
    sb_side_d.v2c = sat32({{3{m2_side.v1c[31]}}, m2_side.v1c} +
                          {{3{m2_side.m_b[31]}}, m2_side.m_b});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_vld_q <= 1'b0;
    end else if (en) begin
      sb_vld_q <= m2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_side_q <= sb_side_d;
    end
  end

  // third multiplier: cube term of the jerk-only plan
  side_t              m3_side;
  logic signed [31:0] m3_a [M3Lanes];
  logic signed [31:0] m3_b [M3Lanes];
  logic signed [31:0] m3_r [M3Lanes];
  logic               m3_vld;

  assign m3_a[0] = sb_side_q.q2;
  assign m3_b[0] = $signed({1'b0, sb_side_q.tp});

  scsp_qmul #(
    .FRAC_BITS (FRACTION_BITS),
    .LANES     (M3Lanes)
  ) u_mul3 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sb_vld_q),
    .side_i  (sb_side_q),
    .a_i     (m3_a),
    .b_i     (m3_b),
    .valid_o (m3_vld),
    .side_o  (m3_side),
    .r_o     (m3_r)
  );

  // stage c: magnitude of the jerk term times the reciprocal of six
  side_t              sc_side_d, sc_side_q;
  logic               sc_vld_q;
  logic signed [31:0] pd;
  logic [31:0]        pd_mag;
  logic [63:0]        prod_q;
  logic               neg_q;

  always_comb begin
    sc_side_d    = m3_side;
    sc_side_d.q3 = m3_r[0];
    pd     = m3_side.cphase ? m3_side.pp : m3_r[0];
    pd_mag = pd[31] ? 32'(-pd) : pd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_vld_q <= 1'b0;
    end else if (en) begin
      sc_vld_q <= m3_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sc_side_q <= sc_side_d;
      prod_q    <= 64'(pd_mag) * 64'(Div6Recip);
      neg_q     <= pd[31];
    end
  end

  // stage d: x1
  side_t              sd_side_d, sd_side_q;
  logic               sd_vld_q;
  logic [63:0]        quo6;
  logic signed [31:0] p6, base;

  always_comb begin
    quo6 = prod_q >> Div6Shift;
    p6   = neg_q ? 32'(-quo6[31:0]) : quo6[31:0];
    base = sc_side_q.cphase ? sc_side_q.m_c : sc_side_q.m_f;
    sd_side_d    = sc_side_q;
    sd_side_d.x1 = sat32({{3{base[31]}}, base} + {{3{p6[31]}}, p6});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sd_vld_q <= 1'b0;
    end else if (en) begin
      sd_vld_q <= sc_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_side_q <= sd_side_d;
    end
  end

  // result assembly into the output buffer
  res_t res;

  always_comb begin
    res.cphase = sd_side_q.cphase;
    res.am     = sd_side_q.am;
    res.jm     = sd_side_q.jm;
    res.t1     = sd_side_q.cphase ? sd_side_q.tc : sd_side_q.tp;
    res.t2     = sd_side_q.cphase ? sd_side_q.qa : sd_side_q.tp;
    res.t3     = sd_side_q.cphase ? sd_side_q.t3c : {sd_side_q.tp[29:0], 1'b0};
    res.v1     = sd_side_q.cphase ? sd_side_q.v1c : sd_side_q.avg;
    res.v2     = sd_side_q.cphase ? sd_side_q.v2c : sd_side_q.avg;
    res.x1     = sd_side_q.x1;
    res.x2     = sd_side_q.cphase ?
                 sat32({{3{sd_side_q.x1[31]}}, sd_side_q.x1} +
                       {{3{sd_side_q.m_h[31]}}, sd_side_q.m_h}) : sd_side_q.x1;
    res.x3     = sd_side_q.cphase ? sd_side_q.m_d :
                 sat32({{2{sd_side_q.m_f[31]}}, sd_side_q.m_f, 1'b0});
  end

  res_t out_res;

  scsp_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (sd_vld_q && en),
    .data_i  (res),
    .stall_i (out_stall_i),
    .valid_o (out_valid_o),
    .data_o  (out_res),
    .full_o  (skid_full),
    .count_o (skid_count)
  );

  assign has_constant_phase_o      = out_res.cphase;
  assign signed_accel_o            = out_res.am;
  assign signed_jerk_o             = out_res.jm;
  assign time_end_ramp_up_o        = out_res.t1;
  assign time_end_constant_o       = out_res.t2;
  assign time_total_o              = out_res.t3;
  assign velocity_after_ramp_up_o  = out_res.v1;
  assign velocity_after_constant_o = out_res.v2;
  assign position_after_ramp_up_o  = out_res.x1;
  assign position_after_constant_o = out_res.x2;
  assign position_total_o          = out_res.x3;

  // buffer never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_count != 2'd3)
    else $error("output buffer overflow");

  // a full buffer freezes the last stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   skid_full |=> $stable(sd_vld_q))
    else $error("pipeline moved while buffer full");

  // constant phase means a positive middle interval
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o && has_constant_phase_o |->
                   time_end_constant_o > time_end_ramp_up_o)
    else $error("constant phase without positive duration");

  // jerk-only plan has coincident first two boundaries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o && !has_constant_phase_o |->
                   time_end_constant_o == time_end_ramp_up_o &&
                   velocity_after_constant_o == velocity_after_ramp_up_o)
    else $error("jerk-only plan boundaries differ");

endmodule
